// ===== design/mbpb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the bitmap to page byte converter
// no dependencies

package mbpb_pkg;

    localparam int WIDTH_PIXELS_DEF  = 128;
    localparam int HEIGHT_PIXELS_DEF = 64;

    localparam int BAND_LINES        = 8;
    localparam int STORED_LINES      = 7;
    localparam int PIXEL_BITS        = 8;
    localparam int INDEX_W           = 10;
    localparam int INDEX_HI_W        = 7;
    localparam int LANE_W            = 3;

    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = 2;
    localparam int QCNT_W            = 3;

    localparam logic [LANE_W-1:0] LAST_LANE = 3'd7;

    typedef struct packed {
        logic [BAND_LINES-1:0][PIXEL_BITS-1:0] rows;
        logic [INDEX_HI_W-1:0]                 index_hi;
    } job_t;

endpackage

// ===== design/mbpb_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module mbpb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mbpb_front.sv =====
`timescale 1ns / 1ps
// front end: position tracking, band line storage and job build
// depends on mbpb_pkg and mbpb_ram

module mbpb_front #(
    parameter int WIDTH_PIXELS  = mbpb_pkg::WIDTH_PIXELS_DEF,
    parameter int HEIGHT_PIXELS = mbpb_pkg::HEIGHT_PIXELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  image_byte,
    input  logic [mbpb_pkg::QCNT_W-1:0] q_count,
    output logic                        q_push,
    output mbpb_pkg::job_t              q_job
);

    localparam int LINE_BYTES = WIDTH_PIXELS / 8;
    localparam int COL_W      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LINE_W     = $clog2(HEIGHT_PIXELS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(LINE_BYTES - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(HEIGHT_PIXELS - 1);
    localparam logic [mbpb_pkg::QCNT_W-1:0] Q_FULL =
        mbpb_pkg::QCNT_W'(mbpb_pkg::QUEUE_DEPTH);
    localparam logic [mbpb_pkg::QCNT_W-1:0] Q_ALMOST =
        mbpb_pkg::QCNT_W'(mbpb_pkg::QUEUE_DEPTH - 1);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic              pend_reg;
    logic [7:0]        pend_byte_reg;
    logic [mbpb_pkg::INDEX_HI_W-1:0] pend_hi_reg;

    logic              accept;
    logic              line7;
    logic [2:0]        band_line;
    logic [31:0]       base_full;
    logic [mbpb_pkg::STORED_LINES-1:0][7:0] rd_data;

    assign band_line = line_reg[2:0];
    assign line7     = (band_line == 3'd7);
    assign full      = line7 && (pend_reg ? (q_count >= Q_ALMOST) : (q_count >= Q_FULL));
    assign accept    = push && !full;
    assign base_full = 32'(line_reg >> 3) * 32'(WIDTH_PIXELS) + 32'(col_reg) * 32'd8;

    genvar i;
    generate
        for (i = 0; i < mbpb_pkg::STORED_LINES; i++)
        begin : g_line
            mbpb_ram #(
                .DATA_W (8),
                .DEPTH  (LINE_BYTES),
                .ADDR_W (COL_W)
            ) u_ram (
                .clk   (clk),
                .we    (accept && !line7 && (band_line == 3'(i))),
                .waddr (col_reg),
                .wdata (image_byte),
                .re    (accept && line7),
                .raddr (col_reg),
                .rdata (rd_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (accept)
        begin
            if (col_reg == LAST_COL)
            begin
                col_next  = '0;
                line_next = (line_reg == LAST_LINE) ? '0 : line_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
            pend_reg <= accept && line7;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && line7)
        begin
            pend_byte_reg <= image_byte;
            pend_hi_reg   <= base_full[mbpb_pkg::INDEX_W-1:3];
        end
    end

    assign q_push             = pend_reg;
    assign q_job.rows         = {pend_byte_reg, rd_data};
    assign q_job.index_hi     = pend_hi_reg;

    a_pend_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (q_count < Q_FULL))
        else $error("job pending with no queue room");

    a_no_store_on_line7: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && line7) |=> pend_reg)
        else $error("line 7 item did not produce a job");

endmodule

// ===== design/mbpb_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front and back
// depends on mbpb_pkg

module mbpb_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  mbpb_pkg::job_t              push_job,
    input  logic                        pop,
    output mbpb_pkg::job_t              head_job,
    output logic                        not_empty,
    output logic [mbpb_pkg::QCNT_W-1:0] count
);

    localparam logic [mbpb_pkg::QCNT_W-1:0] Q_FULL =
        mbpb_pkg::QCNT_W'(mbpb_pkg::QUEUE_DEPTH);

    mbpb_pkg::job_t                  mem_reg [mbpb_pkg::QUEUE_DEPTH];
    logic [mbpb_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [mbpb_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [mbpb_pkg::QCNT_W-1:0]     count_reg;
    logic                            do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == Q_FULL) |-> !push)
        else $error("push into full job queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_FULL)
        else $error("job queue count out of range");

endmodule

// ===== design/mbpb_back.sv =====
`timescale 1ns / 1ps
// back end: expands one job into eight page bytes
// depends on mbpb_pkg

module mbpb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mbpb_pkg::job_t      head_job,
    input  logic                q_not_empty,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          page_byte,
    output logic [9:0]          buffer_index,
    output logic                last_of_run
);

    mbpb_pkg::job_t                  job_reg;
    logic                            valid_reg;
    logic [mbpb_pkg::LANE_W-1:0]     lane_reg;
    logic [mbpb_pkg::LANE_W-1:0]     bit_sel;
    logic                            taken;
    logic                            done;

    assign taken = pop && valid_reg;
    assign done  = taken && (lane_reg == mbpb_pkg::LAST_LANE);
    assign q_pop = q_not_empty && (!valid_reg || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lane_reg  <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                valid_reg <= 1'b1;
                lane_reg  <= '0;
            end
            else if (done)
            begin
                valid_reg <= 1'b0;
            end
            else if (taken)
            begin
                lane_reg <= lane_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head_job;
        end
    end

    assign bit_sel = mbpb_pkg::LAST_LANE - lane_reg;

    always_comb
    begin
        for (int p = 0; p < mbpb_pkg::BAND_LINES; p++)
        begin
            page_byte[p] = job_reg.rows[p][bit_sel];
        end
    end

    assign empty        = !valid_reg;
    assign buffer_index = {job_reg.index_hi, lane_reg};
    assign last_of_run  = (lane_reg == mbpb_pkg::LAST_LANE);

    a_mid_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && !done) |=> valid_reg)
        else $error("run ended before eighth byte");

    a_new_run_lane0: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (valid_reg && lane_reg == '0))
        else $error("new run did not start at lane zero");

endmodule

// ===== design/mono_bitmap_to_page_bytes.sv =====
`timescale 1ns / 1ps
// top level of the bitmap to page byte converter
// depends on mbpb_pkg, mbpb_front, mbpb_queue, mbpb_back

// Accepts a row-major one-bit image, WIDTH_PIXELS/8 bytes per line, and
// emits page bytes (8 vertical pixels, bit p is band line p). Items of band
// lines 0 to 6 are stored in seven line rams and are taken every cycle with
// no result. Each item of band line 7 reads all seven rams at its column
// and queues a job; the back end then gives its 8 results, one per cycle
// while pop is held, leftmost pixel first, the eighth marked last_of_run. A
// four-job queue sits between the two, so during a line 7 burst full rises
// once the queue fills; an item is then taken only when the back end pops
// a job. A line 7 item passes pend_reg, the job queue and the back end job
// register before its first page byte appears.

module mono_bitmap_to_page_bytes #(
    parameter int WIDTH_PIXELS  = mbpb_pkg::WIDTH_PIXELS_DEF,
    parameter int HEIGHT_PIXELS = mbpb_pkg::HEIGHT_PIXELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] image_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] page_byte,
    output logic [9:0] buffer_index,
    output logic       last_of_run
);

    logic                        q_push;
    logic                        q_pop;
    logic                        q_not_empty;
    logic [mbpb_pkg::QCNT_W-1:0] q_count;
    mbpb_pkg::job_t              q_in_job;
    mbpb_pkg::job_t              q_head_job;

    mbpb_front #(
        .WIDTH_PIXELS  (WIDTH_PIXELS),
        .HEIGHT_PIXELS (HEIGHT_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .image_byte (image_byte),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_job      (q_in_job)
    );

    mbpb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in_job),
        .pop       (q_pop),
        .head_job  (q_head_job),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    mbpb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (q_head_job),
        .q_not_empty  (q_not_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .page_byte    (page_byte),
        .buffer_index (buffer_index),
        .last_of_run  (last_of_run)
    );

endmodule
